@@ rtl/pyramid_upsample_5x5_core_assert.svh @@
// Assertion helpers shared by the upsampler RTL.
// Both sample on i_clk and are switched off while i_rst_n is low.
`ifndef PYRAMID_UPSAMPLE_5X5_CORE_ASSERT_SVH
`define PYRAMID_UPSAMPLE_5X5_CORE_ASSERT_SVH

// Plain property, checked every cycle out of reset.
`define PU5_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next.
`define PU5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pu5_pkg.sv @@
package pu5_pkg;

    // field widths
    localparam int PIX_W     = 17;
    localparam int SUM_W     = 19;
    localparam int COEF_W    = 16;
    localparam int KP_W      = 32;
    localparam int PROD_W    = 52;
    localparam int ACC_W     = 54;
    localparam int POS_W     = 13;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd4;

    // pixel formats; anything else is signed 16 bit
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_U16 = 2'd1;

    // coefficient product slots
    localparam int KP_OO = 0;
    localparam int KP_OC = 1;
    localparam int KP_CC = 2;
    localparam int KP_IO = 3;
    localparam int KP_IC = 4;
    localparam int KP_II = 5;
    localparam int KP_N  = 6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRD0,
        S_DRD1,
        S_DRD2,
        S_DCAP,
        S_DLD,
        S_MRD,
        S_MWR,
        S_MA,
        S_MB
    } t_state;

    function automatic logic signed [SUM_W-1:0] px_ext(input logic signed [PIX_W-1:0] x);
        return {{(SUM_W-PIX_W){x[PIX_W-1]}}, x};
    endfunction

    function automatic logic signed [ACC_W-1:0] prod_ext(input logic signed [PROD_W-1:0] x);
        return {{(ACC_W-PROD_W){x[PROD_W-1]}}, x};
    endfunction

endpackage

@@ rtl/pyramid_upsample_5x5_core.sv @@
// A beat passes the sequencer, the job registers and the sum, product and output registers.
// Throughput: one result per cycle while the output is not stalled; a source column gives
// 4 results. A source pixel passes the idle, read, write and job-load states (single-port
// line memory read then write); each last-row drain column adds three line memory reads.
// Emission overlaps the sequencer. Reset (synchronous, active low) clears control, counters,
// drain enable and the window; the line memory is not cleared and needs no clearing pass.
module pyramid_upsample_5x5_core
    import pu5_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int SHIFT_Q    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    // source stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [23:0]          i_s_axis_tdata,   // [15:0] pixel_in
    input  logic                 i_s_axis_tlast,   // row_end
    input  logic                 i_s_axis_tuser,   // frame_end
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [47:0]          o_m_axis_tdata,   // [16:0] pixel_out, [29:17] out_col,
                                                   // [42:30] out_row
    output logic                 o_m_axis_tlast    // run_last
);

    localparam int CW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DWW = CW + 1;
    localparam int SH  = 2 * SHIFT_Q;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'((64'd1 << SH) >> 1);

    // ---------------- configuration ----------------
    logic              r_border;
    logic [1:0]        r_fmt;
    logic [COEF_W-1:0] r_ko, r_ki, r_kc;
    logic [KP_W-1:0]   r_kp [KP_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border <= 1'b0;
            r_fmt    <= FMT_U8;
            r_ko     <= 16'd32;
            r_ki     <= 16'd128;
            r_kc     <= 16'd192;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BORDER: r_border <= i_cfg_data[0];
                CFG_FORMAT: r_fmt    <= i_cfg_data[1:0];
                CFG_OUTER:  r_ko     <= i_cfg_data;
                CFG_INNER:  r_ki     <= i_cfg_data;
                CFG_CENTER: r_kc     <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // pairwise weight products, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_kp[KP_OO] <= r_ko * r_ko;
        r_kp[KP_OC] <= r_ko * r_kc;
        r_kp[KP_CC] <= r_kc * r_kc;
        r_kp[KP_IO] <= r_ki * r_ko;
        r_kp[KP_IC] <= r_ki * r_kc;
        r_kp[KP_II] <= r_ki * r_ki;
    end

    // ---------------- declarations ----------------
    t_state r_state, n_state;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [CW-1:0]           r_sx;
    logic [RW-1:0]           r_r;
    logic                    r_fe;
    logic signed [PIX_W-1:0] r_v, r_h1, r_h2;
    logic                    r_has_a, r_has_b;

    logic          r_dr_on, r_dr_single, r_dr_cnt, r_dr_post;
    logic [CW-1:0] r_dr_col;
    logic [DWW-1:0] r_dr_w;
    logic [RW-1:0] r_dr_row;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [CW-1:0]      rd_addr;
    logic               mem_we;

    logic signed [PIX_W-1:0] r_wp [3];
    logic signed [PIX_W-1:0] r_wc [3];
    logic signed [PIX_W-1:0] r_gp [3];
    logic signed [PIX_W-1:0] r_gc [3];

    logic signed [PIX_W-1:0] r_jp [3], r_jc [3], r_jn [3];
    logic [POS_W-1:0]        r_jrow, r_jcol;
    logic                    r_jlast;

    logic       r_em_busy;
    logic [1:0] r_em_phase;

    logic signed [SUM_W-1:0] r_ss [3];
    logic [KP_W-1:0]         r_sk [3];
    logic [POS_W-1:0]        r_s_row, r_s_col;
    logic                    r_s_last, r_s_vld;

    logic signed [PROD_W-1:0] r_mp [3];
    logic [POS_W-1:0]         r_m_row, r_m_col;
    logic                     r_m_last, r_m_vld;

    logic               r_o_vld, r_o_last;
    logic [PIX_W-1:0]   r_o_pix;
    logic [POS_W-1:0]   r_o_row, r_o_col;

    logic s_ready, acc, en, want_load, job_load;

    // ---------------- input beat decode ----------------
    logic                    in_re, in_fe;
    logic signed [PIX_W-1:0] in_v;

    assign acc = i_s_axis_tvalid && s_ready;
    assign en  = !r_o_vld || i_m_axis_tready;

    always_comb begin
        in_re = i_s_axis_tlast || i_s_axis_tuser || (r_col == CW'(MAX_WIDTH - 1));
        in_fe = i_s_axis_tuser || (in_re && (r_row == RW'(MAX_HEIGHT - 1)));
        case (r_fmt)
            FMT_U8:  in_v = {9'd0, i_s_axis_tdata[7:0]};
            FMT_U16: in_v = {1'b0, i_s_axis_tdata[15:0]};
            default: in_v = {i_s_axis_tdata[15], i_s_axis_tdata[15:0]};
        endcase
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (in_re) begin
                r_col <= '0;
                r_row <= in_fe ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // per-beat context
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_sx    <= r_col;
            r_r     <= r_row;
            r_fe    <= in_fe;
            r_v     <= in_v;
            r_h1    <= r_v;
            r_h2    <= r_h1;
            r_has_a <= (r_row != '0) && (r_col != '0);
            r_has_b <= (r_row != '0) && in_re;
        end
    end

    // ---------------- drain of the last row ----------------
    logic [CW-1:0] dr_idx0, dr_idx2;
    logic          dr_end;

    always_comb begin
        if (r_dr_col == '0)
            dr_idx0 = (r_border && (r_dr_w >= DWW'(2))) ? CW'(1) : '0;
        else
            dr_idx0 = r_dr_col - CW'(1);
        dr_idx2 = (({1'b0, r_dr_col} + DWW'(1)) < r_dr_w) ? r_dr_col + CW'(1) : r_dr_col;
        dr_end  = r_dr_cnt || (({1'b0, r_dr_col} + DWW'(1)) >= r_dr_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dr_on  <= 1'b0;
            r_dr_cnt <= 1'b0;
        end else if (acc) begin
            r_dr_cnt  <= 1'b0;
            r_dr_post <= in_fe;
            if (in_fe) begin
                // a new frame end drops any pending drain and arms its own
                r_dr_on     <= 1'b1;
                r_dr_col    <= '0;
                r_dr_w      <= {1'b0, r_col} + DWW'(1);
                r_dr_row    <= r_row;
                r_dr_single <= (r_row == '0);
            end
        end else if (r_state == S_DLD && job_load) begin
            r_dr_col <= r_dr_col + CW'(1);
            r_dr_cnt <= 1'b1;
            if (({1'b0, r_dr_col} + DWW'(1)) >= r_dr_w)
                r_dr_on <= 1'b0;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc) n_state = (in_fe || !r_dr_on) ? S_MRD : S_DRD0;
            S_DRD0: n_state = S_DRD1;
            S_DRD1: n_state = S_DRD2;
            S_DRD2: n_state = S_DCAP;
            S_DCAP: n_state = S_DLD;
            S_DLD: begin
                if (job_load) begin
                    if (!dr_end)        n_state = S_DRD0;
                    else if (r_dr_post) n_state = S_IDLE;
                    else                n_state = S_MRD;
                end
            end
            S_MRD: n_state = S_MWR;
            S_MWR: n_state = S_MA;
            S_MA:  if (!r_has_a || job_load) n_state = S_MB;
            S_MB:  if (!r_has_b || job_load) n_state = r_fe ? S_DRD0 : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        rd_addr   = r_sx;
        mem_we    = 1'b0;
        want_load = 1'b0;
        unique case (r_state)
            S_IDLE: s_ready   = 1'b1;
            S_DRD0: rd_addr   = dr_idx0;
            S_DRD1: rd_addr   = r_dr_col;
            S_DRD2: rd_addr   = dr_idx2;
            S_DLD:  want_load = 1'b1;
            S_MWR:  mem_we    = 1'b1;
            S_MA:   want_load = r_has_a;
            S_MB:   want_load = r_has_b;
            default: ;
        endcase
    end

    assign o_s_axis_tready = s_ready;
    assign job_load = want_load && en && (!r_em_busy || (r_em_phase == 2'd3));

    // ---------------- line memory: {prev, cur} per column ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[r_sx] <= {r_rd[PIX_W-1:0], r_v};
        r_rd <= mem[rd_addr];
    end

    // column window of the two rows above
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_wp[i] <= '0;
                r_wc[i] <= '0;
            end
        end else if (r_state == S_MWR) begin
            r_wp[0] <= r_wp[1];
            r_wp[1] <= r_wp[2];
            r_wp[2] <= r_rd[2*PIX_W-1:PIX_W];
            r_wc[0] <= r_wc[1];
            r_wc[1] <= r_wc[2];
            r_wc[2] <= r_rd[PIX_W-1:0];
        end
    end

    // drain column gather, one read per cycle
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_DRD1: begin
                r_gc[0] <= r_rd[PIX_W-1:0];
                r_gp[0] <= r_dr_single ? r_rd[PIX_W-1:0] : r_rd[2*PIX_W-1:PIX_W];
            end
            S_DRD2: begin
                r_gc[1] <= r_rd[PIX_W-1:0];
                r_gp[1] <= r_dr_single ? r_rd[PIX_W-1:0] : r_rd[2*PIX_W-1:PIX_W];
            end
            S_DCAP: begin
                r_gc[2] <= r_rd[PIX_W-1:0];
                r_gp[2] <= r_dr_single ? r_rd[PIX_W-1:0] : r_rd[2*PIX_W-1:PIX_W];
            end
            default: ;
        endcase
    end

    // ---------------- job selection ----------------
    logic signed [PIX_W-1:0] mn [3], mp [3];
    logic signed [PIX_W-1:0] j_p [3], j_c [3], j_n [3];
    logic [POS_W-1:0]        j_row, j_col;
    logic                    j_last;
    logic [1:0]              la, lb;
    logic [31:0]             t_mrow, t_cola, t_colb, t_drow, t_dcol;

    always_comb begin
        mn[0] = (32'(r_sx) >= 32'd2) ? r_h2 : '0;
        mn[1] = (32'(r_sx) >= 32'd1) ? r_h1 : '0;
        mn[2] = r_v;
        // row above row 0 follows the border rule
        for (int i = 0; i < 3; i++)
            mp[i] = (r_r == RW'(1)) ? (r_border ? mn[i] : r_wc[i]) : r_wp[i];
        la = (r_sx == CW'(1)) ? (r_border ? 2'd2 : 2'd1) : 2'd0;
        lb = (r_sx == '0) ? 2'd2 : 2'd1;

        t_mrow = (32'(r_r) << 1) - 32'd2;
        t_cola = (32'(r_sx) << 1) - 32'd2;
        t_colb = 32'(r_sx) << 1;
        t_drow = 32'(r_dr_row) << 1;
        t_dcol = 32'(r_dr_col) << 1;

        if (r_state == S_MA) begin
            j_p[0] = mp[la];   j_p[1] = mp[1];   j_p[2] = mp[2];
            j_c[0] = r_wc[la]; j_c[1] = r_wc[1]; j_c[2] = r_wc[2];
            j_n[0] = mn[la];   j_n[1] = mn[1];   j_n[2] = mn[2];
            j_row  = t_mrow[POS_W-1:0];
            j_col  = t_cola[POS_W-1:0];
            j_last = !r_has_b && !r_fe;
        end else if (r_state == S_MB) begin
            j_p[0] = mp[lb];   j_p[1] = mp[2];   j_p[2] = mp[2];
            j_c[0] = r_wc[lb]; j_c[1] = r_wc[2]; j_c[2] = r_wc[2];
            j_n[0] = mn[lb];   j_n[1] = mn[2];   j_n[2] = mn[2];
            j_row  = t_mrow[POS_W-1:0];
            j_col  = t_colb[POS_W-1:0];
            j_last = !r_fe;
        end else begin
            // drain: the row below is the row itself
            for (int i = 0; i < 3; i++) begin
                j_p[i] = r_gp[i];
                j_c[i] = r_gc[i];
                j_n[i] = r_gc[i];
            end
            j_row  = t_drow[POS_W-1:0];
            j_col  = t_dcol[POS_W-1:0];
            j_last = dr_end && (r_dr_post || (!r_has_a && !r_has_b));
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_load) begin
            for (int i = 0; i < 3; i++) begin
                r_jp[i] <= j_p[i];
                r_jc[i] <= j_c[i];
                r_jn[i] <= j_n[i];
            end
            r_jrow  <= j_row;
            r_jcol  <= j_col;
            r_jlast <= j_last;
        end
    end

    // ---------------- emitter: four phases per column ----------------
    logic signed [SUM_W-1:0] e_s [3];
    logic [KP_W-1:0]         e_k [3];
    logic [POS_W-1:0]        e_row, e_col;
    logic                    e_last;

    always_comb begin
        e_s[2] = '0;
        e_k[2] = '0;
        e_row  = r_jrow;
        e_col  = r_jcol;
        e_last = 1'b0;
        unique case (r_em_phase)
            2'd0: begin
                e_s[0] = px_ext(r_jp[0]) + px_ext(r_jp[2]) + px_ext(r_jn[0]) + px_ext(r_jn[2]);
                e_k[0] = r_kp[KP_OO];
                e_s[1] = px_ext(r_jp[1]) + px_ext(r_jn[1]) + px_ext(r_jc[0]) + px_ext(r_jc[2]);
                e_k[1] = r_kp[KP_OC];
                e_s[2] = px_ext(r_jc[1]);
                e_k[2] = r_kp[KP_CC];
            end
            2'd1: begin
                e_s[0] = px_ext(r_jp[1]) + px_ext(r_jn[1]) + px_ext(r_jp[2]) + px_ext(r_jn[2]);
                e_k[0] = r_kp[KP_IO];
                e_s[1] = px_ext(r_jc[1]) + px_ext(r_jc[2]);
                e_k[1] = r_kp[KP_IC];
                e_col  = r_jcol + POS_W'(1);
            end
            2'd2: begin
                e_s[0] = px_ext(r_jc[0]) + px_ext(r_jn[0]) + px_ext(r_jc[2]) + px_ext(r_jn[2]);
                e_k[0] = r_kp[KP_IO];
                e_s[1] = px_ext(r_jc[1]) + px_ext(r_jn[1]);
                e_k[1] = r_kp[KP_IC];
                e_row  = r_jrow + POS_W'(1);
            end
            2'd3: begin
                e_s[0] = px_ext(r_jc[1]) + px_ext(r_jn[1]) + px_ext(r_jc[2]) + px_ext(r_jn[2]);
                e_k[0] = r_kp[KP_II];
                e_s[1] = '0;
                e_k[1] = '0;
                e_row  = r_jrow + POS_W'(1);
                e_col  = r_jcol + POS_W'(1);
                e_last = r_jlast;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_busy  <= 1'b0;
            r_em_phase <= 2'd0;
            r_s_vld    <= 1'b0;
            r_m_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
        end else if (en) begin
            if (job_load) begin
                r_em_busy  <= 1'b1;
                r_em_phase <= 2'd0;
            end else if (r_em_busy) begin
                r_em_phase <= r_em_phase + 2'd1;
                if (r_em_phase == 2'd3)
                    r_em_busy <= 1'b0;
            end
            r_s_vld <= r_em_busy;
            r_m_vld <= r_s_vld;
            r_o_vld <= r_m_vld;
        end
    end

    // ---------------- arithmetic pipe ----------------
    logic signed [ACC_W-1:0] acc_sum, acc_rnd, acc_sh;
    logic signed [ACC_W-1:0] sat_lo, sat_hi, sat_v;

    always_comb begin
        acc_sum = prod_ext(r_mp[0]) + prod_ext(r_mp[1]) + prod_ext(r_mp[2]);
        acc_rnd = acc_sum + HALF;
        acc_sh  = acc_rnd >>> SH;
        case (r_fmt)
            FMT_U8: begin
                sat_lo = '0;
                sat_hi = ACC_W'(255);
            end
            FMT_U16: begin
                sat_lo = '0;
                sat_hi = ACC_W'(65535);
            end
            default: begin
                sat_lo = -ACC_W'(32768);
                sat_hi = ACC_W'(32767);
            end
        endcase
        if (acc_sh < sat_lo)      sat_v = sat_lo;
        else if (acc_sh > sat_hi) sat_v = sat_hi;
        else                      sat_v = acc_sh;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_ss[i] <= e_s[i];
                r_sk[i] <= e_k[i];
                r_mp[i] <= r_ss[i] * $signed({1'b0, r_sk[i]});
            end
            r_s_row  <= e_row;
            r_s_col  <= e_col;
            r_s_last <= e_last;
            r_m_row  <= r_s_row;
            r_m_col  <= r_s_col;
            r_m_last <= r_s_last;
            r_o_pix  <= sat_v[PIX_W-1:0];
            r_o_row  <= r_m_row;
            r_o_col  <= r_m_col;
            r_o_last <= r_m_last;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {5'd0, r_o_row, r_o_col, r_o_pix};
    assign o_m_axis_tlast  = r_o_last;

    // ---------------- assertions ----------------
    `include "pyramid_upsample_5x5_core_assert.svh"

    `PU5_ASSERT(a_drain_in_range, !r_dr_on || (32'(r_dr_col) < 32'(r_dr_w)), "drain past width")
    `PU5_ASSERT_NEXT(a_accept_leaves_idle, acc, r_state != S_IDLE, "idle after accept")
    `PU5_ASSERT_NEXT(a_phase_run, en && r_em_busy && (r_em_phase != 2'd3), r_em_busy, "column cut short")

endmodule
